[rtl/rme_pkg.sv]
package rme_pkg;

  // Fixed arithmetic layout
  localparam int unsigned TableLen = 24;
  localparam int unsigned PreShift = 24;
  localparam int unsigned RootPrec = 30;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned RemW = 61;
  localparam int unsigned ResW = 63;
  localparam int unsigned CordW = 60;
  localparam int unsigned ZW = 34;

  localparam logic [31:0] BamToRadK = 32'd3373259426;
  localparam logic [63:0] RoundHalf = 64'd1 << 47;
  localparam logic [15:0] RadPiQ13 = 16'd25736;
  localparam logic [15:0] RadHalfPiQ13 = 16'd12868;
  localparam logic signed [ZW-1:0] BamQuarter = ZW'(64'sd1073741824);

  // atan(2^-i) as binary angle, 2^32 is one turn
  localparam logic [31:0] AtanBam [TableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef enum logic [1:0] {
    LockNone = 2'd0,
    LockUp   = 2'd1,
    LockDown = 2'd2
  } lock_e;

  // Operands that ride alongside the square root
  typedef struct packed {
    lock_e              lock;
    logic signed [31:0] s;
    logic signed [16:0] roll_y;
    logic signed [16:0] roll_x;
    logic signed [15:0] yaw_y;
    logic signed [15:0] yaw_x;
  } side_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    zero;
  } cord_t;

  typedef struct packed {
    cord_t pitch;
    cord_t roll;
    cord_t yaw;
    lock_e lock;
  } cstage_t;

  // Preshift and fold the left half plane onto the right
  function automatic cord_t cordic_prep(logic signed [CordW-1:0] y0,
                                        logic signed [CordW-1:0] x0);
    cord_t c;
    logic signed [CordW-1:0] xs;
    logic signed [CordW-1:0] ys;
    xs = x0 <<< PreShift;
    ys = y0 <<< PreShift;
    c.zero = (x0 == '0) && (y0 == '0);
    c.x = xs;
    c.y = ys;
    c.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        c.x = ys;
        c.y = -xs;
        c.z = BamQuarter;
      end else begin
        c.x = -ys;
        c.y = xs;
        c.z = -BamQuarter;
      end
    end
    return c;
  endfunction

  // One vectoring micro-rotation
  function automatic cord_t cordic_rot(cord_t c, int unsigned step);
    cord_t r;
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    logic signed [ZW-1:0]    a;
    dx = c.y >>> step;
    dy = c.x >>> step;
    a = signed'(ZW'(AtanBam[step]));
    r = c;
    if (c.y >= 0) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + a;
    end else begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - a;
    end
    return r;
  endfunction

endpackage

[rtl/rme_sqrt_cell.sv]
module rme_sqrt_cell import rme_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RemW-1:0] rem_i,
  input  logic [ResW-1:0] res_i,
  input  side_t           side_i,
  output logic [RemW-1:0] rem_o,
  output logic [ResW-1:0] res_o,
  output side_t           side_o
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Step);

  logic [63:0]     trial;
  logic [RemW-1:0] rem_d;
  logic [ResW-1:0] res_d;

  // Try one result bit pair, keep it if the remainder allows
  always_comb begin
    trial = {1'b0, res_i} + Bit;
    if ({3'b0, rem_i} >= trial) begin
      rem_d = RemW'({3'b0, rem_i} - trial);
      res_d = ResW'({2'b0, res_i[ResW-1:1]} + Bit);
    end else begin
      rem_d = rem_i;
      res_d = {1'b0, res_i[ResW-1:1]};
    end
  end

  // Hand to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      res_o  <= res_d;
      side_o <= side_i;
    end
  end

endmodule

[rtl/rme_cordic_cell.sv]
module rme_cordic_cell import rme_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cstage_t stage_i,
  output cstage_t stage_o
);

  cstage_t stage_d;

  // Rotate all three lanes by the same step
  always_comb begin
    stage_d       = stage_i;
    stage_d.pitch = cordic_rot(stage_i.pitch, Step);
    stage_d.roll  = cordic_rot(stage_i.roll, Step);
    stage_d.yaw   = cordic_rot(stage_i.yaw, Step);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_o <= stage_d;
    end
  end

endmodule

[rtl/rme_rad_conv.sv]
module rme_rad_conv import rme_pkg::*; #(
  parameter logic [15:0] Limit = 16'd25736
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 zero_i,
  output logic                 neg_o,
  output logic [15:0]          mag_o
);

  logic signed [ZW-1:0] z;
  logic [31:0]          mag;
  logic [63:0]          prod_q;
  logic                 neg_q;
  logic [63:0]          rounded;
  logic [15:0]          q;

  // Take the magnitude of the binary angle
  always_comb begin
    z   = zero_i ? '0 : z_i;
    mag = z[ZW-1] ? 32'(-z) : 32'(z);
  end

  // Scale to radians
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(mag) * 64'(BamToRadK);
      neg_q  <= z[ZW-1];
    end
  end

  // Round half away from zero and clip
  always_comb begin
    rounded = prod_q + RoundHalf;
    q       = rounded[63:48];
    mag_o   = (q > Limit) ? Limit : q;
    neg_o   = neg_q;
  end

endmodule

[rtl/rotation_matrix_to_euler.sv]
// ZYX Euler angles from the rotation part of a homogeneous transform.
// Slave channel: one transaction carries r00, r01, r02, r10, r20, r21, r22,
// each Q1.14 signed. Master channel: yaw and roll in radians as Q2.13,
// pitch as Q1.13, in tdata, and the gimbal lock case in tuser (0 normal,
// 1 pitch up, 2 pitch down). Every input transaction yields exactly one output.
// The pipeline is an input conditioning register, 32 square-root cells, a
// fold register, one CORDIC cell per stage, a multiply register and the
// output register. The pipeline takes one transaction per cycle while the
// receiver does not stall it; its length is set by the square-root and
// CORDIC cell rows.
// When the receiver stalls with a result in the output register, the whole
// pipeline holds; when the output register is empty it keeps moving, so
// bubbles drain. Reset clears all valid bits; no result is shown after
// reset until a transaction has passed through.
module rotation_matrix_to_euler import rme_pkg::*; #(
  parameter int unsigned CORDIC_STAGES   = 16,
  parameter int unsigned INPUT_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r00 [15:0], r01 [31:16], r02 [47:32], r10 [63:48], r20 [79:64],
  // r21 [95:80], r22 [111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // yaw_angle [15:0], roll_angle [31:16], pitch_angle [46:32], zero [47]
  output logic [47:0]  m_axis_tdata,
  // lock_case [1:0]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned Lat = CORDIC_STAGES + 36;
  localparam int unsigned RootShift = RootPrec - INPUT_FRAC_BITS;
  localparam logic signed [31:0] One = 32'sd1 <<< INPUT_FRAC_BITS;
  localparam logic [61:0] RootOne = 62'd1 << (2 * RootPrec);

  logic en;
  logic [Lat-1:0] v_q;

  // Advance unless a result waits on a stalled receiver
  assign en = !v_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Input conditioning
  logic signed [15:0] r00, r01, r02, r10, r20, r21, r22;
  logic signed [31:0] r20w, r20s, s;
  logic [30:0]        sm;
  logic [61:0]        sq;
  side_t              side_d;
  logic [RemW-1:0]    rem_s [RootSteps+1];
  logic [ResW-1:0]    res_s [RootSteps+1];
  side_t              side_s [RootSteps+1];

  assign {r22, r21, r20, r10, r02, r01, r00} = s_axis_tdata;

  always_comb begin
    r20w = 32'(r20);
    priority if (r20w > One) begin
      r20s = One;
    end else if (r20w < -One) begin
      r20s = -One;
    end else begin
      r20s = r20w;
    end
    s  = r20s <<< RootShift;
    sm = s[31] ? 31'(-s) : 31'(s);
    sq = 62'(sm) * 62'(sm);
    side_d.s     = s;
    side_d.yaw_y = r10;
    side_d.yaw_x = r00;
    priority if (r20s == -One) begin
      side_d.lock   = LockUp;
      side_d.roll_y = 17'(r01);
      side_d.roll_x = 17'(r02);
    end else if (r20s == One) begin
      side_d.lock   = LockDown;
      side_d.roll_y = -17'(r01);
      side_d.roll_x = -17'(r02);
    end else begin
      side_d.lock   = LockNone;
      side_d.roll_y = 17'(r21);
      side_d.roll_x = 17'(r22);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_s[0]  <= RemW'(RootOne - sq);
      side_s[0] <= side_d;
    end
  end
  assign res_s[0] = '0;

  // Square-root cell row
  for (genvar j = 0; j < RootSteps; j++) begin : g_root
    rme_sqrt_cell #(.Step(j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_s[j]),
      .res_i  (res_s[j]),
      .side_i (side_s[j]),
      .rem_o  (rem_s[j+1]),
      .res_o  (res_s[j+1]),
      .side_o (side_s[j+1])
    );
  end

  // Fold operands into the CORDIC lanes
  cstage_t cq [CORDIC_STAGES+1];
  side_t   sd;
  assign sd = side_s[RootSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cq[0].pitch <= cordic_prep(CordW'(sd.s), CordW'(res_s[RootSteps]));
      cq[0].roll  <= cordic_prep(CordW'(sd.roll_y), CordW'(sd.roll_x));
      cq[0].yaw   <= cordic_prep(CordW'(sd.yaw_y), CordW'(sd.yaw_x));
      cq[0].lock  <= sd.lock;
    end
  end

  // CORDIC cell row
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    rme_cordic_cell #(.Step(k)) u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .stage_i (cq[k]),
      .stage_o (cq[k+1])
    );
  end

  // Radian conversion
  cstage_t     cl;
  logic        p_neg, r_neg, y_neg;
  logic [15:0] p_mag, r_mag, y_mag;
  lock_e       lock_m_q;
  assign cl = cq[CORDIC_STAGES];

  rme_rad_conv #(.Limit(RadHalfPiQ13)) u_pitch_conv (
    .clk_i (clk_i), .en_i (en), .z_i (cl.pitch.z), .zero_i (cl.pitch.zero),
    .neg_o (p_neg), .mag_o (p_mag)
  );
  rme_rad_conv #(.Limit(RadPiQ13)) u_roll_conv (
    .clk_i (clk_i), .en_i (en), .z_i (cl.roll.z), .zero_i (cl.roll.zero),
    .neg_o (r_neg), .mag_o (r_mag)
  );
  rme_rad_conv #(.Limit(RadPiQ13)) u_yaw_conv (
    .clk_i (clk_i), .en_i (en), .z_i (cl.yaw.z), .zero_i (cl.yaw.zero),
    .neg_o (y_neg), .mag_o (y_mag)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      lock_m_q <= cl.lock;
    end
  end

  // Output register
  logic [15:0] yaw_q, roll_q;
  logic [14:0] pitch_q;
  lock_e       lock_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lock_q <= lock_m_q;
      roll_q <= r_neg ? -r_mag : r_mag;
      unique case (lock_m_q)
        LockUp: begin
          yaw_q   <= '0;
          pitch_q <= 15'(RadHalfPiQ13);
        end
        LockDown: begin
          yaw_q   <= '0;
          pitch_q <= -15'(RadHalfPiQ13);
        end
        default: begin
          yaw_q   <= y_neg ? -y_mag : y_mag;
          pitch_q <= p_neg ? 15'(p_mag) : -15'(p_mag);
        end
      endcase
    end
  end

  assign m_axis_tdata = {1'b0, pitch_q, roll_q, yaw_q};
  assign m_axis_tuser = lock_q;

  // Checks
  a_lock_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("invalid lock case");
  a_lock_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != LockNone) |-> yaw_q == '0)
    else $error("yaw not zero in gimbal lock");
  a_lock_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == LockUp) |-> pitch_q == 15'(RadHalfPiQ13))
    else $error("pitch not half pi in lock up");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("stalled with a free output");

endmodule
